@@ rtl/core/ucfp_pkg.sv @@
// Shared types, sizes and character helpers for the credential form parser.
// No dependencies; imported by every module of the block.
package ucfp_pkg;

  localparam int NAME_MAX  = 32;
  localparam int PASS_MAX  = 64;
  localparam int TOKEN_LEN = 16;

  localparam int POS_W = 7;
  localparam int TOK_W = 5;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] FLD_NAME  = 2'd0;
  localparam logic [1:0] FLD_PASS  = 2'd1;
  localparam logic [1:0] FLD_TOKEN = 2'd2;
  localparam logic [1:0] FLD_BAD   = 2'd3;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_KEY_S = 8'h73;
  localparam logic [7:0] CH_KEY_P = 8'h70;
  localparam logic [7:0] CH_KEY_T = 8'h74;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] key;
    logic       is_eq;
    logic       is_amp;
    logic       is_pct;
    logic       is_plus;
    logic       nib_ok;
    logic [3:0] nib;
  } item_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    nibble_of = v[3:0];
  endfunction

endpackage

@@ rtl/core/ucfp_front.sv @@
// Front end: takes raw body bytes and classifies them for the parser.
// Depends on ucfp_pkg; feeds ucfp_queue.
module ucfp_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,  // body_byte[7:0]
  input  logic          in_tlast,
  input  logic          q_full,
  output logic          q_push,
  output ucfp_pkg::item_t q_item
);
  import ucfp_pkg::*;

  logic [1:0] key;

  always_comb begin
    case (in_tdata)
      CH_KEY_S: key = FLD_NAME;
      CH_KEY_P: key = FLD_PASS;
      CH_KEY_T: key = FLD_TOKEN;
      default:  key = FLD_BAD;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.data    = in_tdata;
    q_item.last    = in_tlast;
    q_item.key     = key;
    q_item.is_eq   = (in_tdata == CH_EQ);
    q_item.is_amp  = (in_tdata == CH_AMP);
    q_item.is_pct  = (in_tdata == CH_PCT);
    q_item.is_plus = (in_tdata == CH_PLUS);
    q_item.nib_ok  = is_hex(in_tdata);
    q_item.nib     = nibble_of(in_tdata);
  end

endmodule

@@ rtl/core/ucfp_queue.sv @@
// Short queue of classified bytes between front end and parser back end.
// Depends on ucfp_pkg.
module ucfp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ucfp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output ucfp_pkg::item_t q_item
);
  import ucfp_pkg::*;

  item_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ rtl/core/ucfp_back.sv @@
// Back end: parser state, percent decoding, checks and the output register.
// Depends on ucfp_pkg; drains ucfp_queue.
module ucfp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ucfp_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,  // char_pos[5:0], char_value[7:0], accepted, pad
  output logic [2:0]      out_tuser,  // char_valid, field[1:0]
  output logic            out_tlast
);
  import ucfp_pkg::*;

  typedef enum logic [2:0] {
    PH_KEY = 3'b001,
    PH_EQ  = 3'b010,
    PH_VAL = 3'b100
  } phase_t;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_ONE  = 2'd1;
  localparam logic [1:0] ESC_TWO  = 2'd2;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         field_r, field_nxt;
  logic [2:0]         seen_r, seen_nxt;
  logic [1:0]         esc_r, esc_nxt;
  logic [3:0]         high_r, high_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               name_ne_r, name_ne_nxt;
  logic [POS_W-1:0]   pass_len_r, pass_len_nxt;
  logic               all_hex_r, all_hex_nxt;
  logic [TOK_W-1:0]   tok_len_r, tok_len_nxt;
  logic               failed_r, failed_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               o_cv_r, o_cv_nxt;
  logic [1:0]         o_field_r, o_field_nxt;
  logic [5:0]         o_pos_r, o_pos_nxt;
  logic [7:0]         o_char_r, o_char_nxt;
  logic               o_done_r, o_done_nxt;
  logic               o_acc_r, o_acc_nxt;

  logic               have;
  logic [7:0]         c;
  logic [3:0]         seen_ext;
  logic [POS_W-1:0]   limit;
  logic               end_ok, pass_ok;

  assign q_pop    = q_valid && (!out_valid_r || out_tready);
  assign seen_ext = {1'b1, seen_r};

  always_comb begin
    case (field_r)
      FLD_NAME: limit = POS_W'(NAME_MAX);
      FLD_PASS: limit = POS_W'(PASS_MAX);
      default:  limit = POS_W'(TOKEN_LEN);
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    field_nxt    = field_r;
    seen_nxt     = seen_r;
    esc_nxt      = esc_r;
    high_nxt     = high_r;
    pos_nxt      = pos_r;
    name_ne_nxt  = name_ne_r;
    pass_len_nxt = pass_len_r;
    all_hex_nxt  = all_hex_r;
    tok_len_nxt  = tok_len_r;
    failed_nxt   = failed_r;
    have         = 1'b0;
    c            = 8'h00;
    o_cv_nxt     = 1'b0;
    o_field_nxt  = 2'd0;
    o_pos_nxt    = 6'd0;
    o_char_nxt   = 8'h00;

    if (!failed_r) begin
      case (phase_r)
        PH_KEY: begin
          if (seen_ext[q_item.key]) begin
            failed_nxt = 1'b1;
          end else begin
            seen_nxt  = seen_r | (3'b001 << q_item.key);
            field_nxt = q_item.key;
            phase_nxt = PH_EQ;
          end
        end
        PH_EQ: begin
          if (q_item.is_eq) begin
            phase_nxt = PH_VAL;
            pos_nxt   = '0;
            esc_nxt   = ESC_NONE;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_VAL: begin
          if (esc_r == ESC_ONE) begin
            if (!q_item.nib_ok) failed_nxt = 1'b1;
            else begin
              high_nxt = q_item.nib;
              esc_nxt  = ESC_TWO;
            end
          end else if (esc_r == ESC_TWO) begin
            if (!q_item.nib_ok) failed_nxt = 1'b1;
            else begin
              c       = {high_r, q_item.nib};
              esc_nxt = ESC_NONE;
              have    = 1'b1;
            end
          end else if (q_item.is_amp) begin
            phase_nxt = PH_KEY;
          end else if (q_item.is_pct) begin
            esc_nxt = ESC_ONE;
          end else begin
            c    = q_item.is_plus ? CH_SPACE : q_item.data;
            have = 1'b1;
          end
        end
        default: failed_nxt = 1'b1;
      endcase

      if (have) begin
        if (c < CH_SPACE || c == CH_DEL || pos_r >= limit) begin
          failed_nxt = 1'b1;
        end else begin
          o_cv_nxt    = 1'b1;
          o_field_nxt = field_r;
          o_pos_nxt   = pos_r[5:0];
          o_char_nxt  = c;
          case (field_r)
            FLD_NAME: name_ne_nxt = 1'b1;
            FLD_PASS: begin
              pass_len_nxt = pos_r + 1'b1;
              if (!is_hex(c)) all_hex_nxt = 1'b0;
            end
            default:  tok_len_nxt = TOK_W'(pos_r + 1'b1);
          endcase
          pos_nxt = pos_r + 1'b1;
        end
      end
    end

    end_ok  = (phase_nxt == PH_KEY) || (phase_nxt == PH_VAL && esc_nxt == ESC_NONE);
    pass_ok = (pass_len_nxt == '0) ||
              (pass_len_nxt >= POS_W'(8) && pass_len_nxt < POS_W'(PASS_MAX)) ||
              (pass_len_nxt == POS_W'(PASS_MAX) && all_hex_nxt);
    o_done_nxt = q_item.last;
    o_acc_nxt  = q_item.last && !failed_nxt && end_ok && (seen_nxt == 3'b111) &&
                 name_ne_nxt && (tok_len_nxt == TOK_W'(TOKEN_LEN)) && pass_ok;

    if (q_item.last) begin
      phase_nxt    = PH_KEY;
      field_nxt    = FLD_NAME;
      seen_nxt     = '0;
      esc_nxt      = ESC_NONE;
      high_nxt     = '0;
      pos_nxt      = '0;
      name_ne_nxt  = 1'b0;
      pass_len_nxt = '0;
      all_hex_nxt  = 1'b1;
      tok_len_nxt  = '0;
      failed_nxt   = 1'b0;
    end
  end

  always_comb begin
    if (q_pop) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEY;
      field_r     <= FLD_NAME;
      seen_r      <= '0;
      esc_r       <= ESC_NONE;
      high_r      <= '0;
      pos_r       <= '0;
      name_ne_r   <= 1'b0;
      pass_len_r  <= '0;
      all_hex_r   <= 1'b1;
      tok_len_r   <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r    <= phase_nxt;
        field_r    <= field_nxt;
        seen_r     <= seen_nxt;
        esc_r      <= esc_nxt;
        high_r     <= high_nxt;
        pos_r      <= pos_nxt;
        name_ne_r  <= name_ne_nxt;
        pass_len_r <= pass_len_nxt;
        all_hex_r  <= all_hex_nxt;
        tok_len_r  <= tok_len_nxt;
        failed_r   <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      o_cv_r    <= o_cv_nxt;
      o_field_r <= o_field_nxt;
      o_pos_r   <= o_pos_nxt;
      o_char_r  <= o_char_nxt;
      o_done_r  <= o_done_nxt;
      o_acc_r   <= o_acc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, o_acc_r, o_char_r, o_pos_r};
  assign out_tuser  = {o_field_r, o_cv_r};
  assign out_tlast  = o_done_r;

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_item.last |=> phase_r == PH_KEY && seen_r == '0 && !failed_r)
    else $error("parser state not cleared after final byte");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r && !(q_pop && q_item.last) |=> failed_r)
    else $error("error flag dropped within a body");

  a_no_char_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && failed_r |=> !o_cv_r)
    else $error("character emitted after error");

  a_accept_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_done_r |-> !o_acc_r)
    else $error("acceptance flagged before final byte");

endmodule

@@ rtl/core/urlencoded_credential_form_parser.sv @@
// Top level of the URL-encoded credential form parser.
// Depends on ucfp_pkg, ucfp_front, ucfp_queue and ucfp_back.
//
// Takes one raw body byte per transfer (in_tlast on the final byte) and gives
// exactly one result transfer per byte: a decoded value character tagged with
// field and position when char_valid is set, and on the final byte the
// acceptance verdict with out_tlast. Throughput is one byte per cycle while
// out_tready stays high; the result for a byte is written into the two-entry
// queue, then parsed into the output register and offered on the output.
// The output register lets the next byte be taken while a result still
// waits; backpressure reaches in_tready once the queue fills.
module urlencoded_credential_form_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // body_byte[7:0]
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // char_pos[5:0], char_value[13:6], accepted[14], zero[15]
  output logic [2:0]  out_tuser,  // char_valid[0], field[2:1]
  output logic        out_tlast   // done_res
);
  import ucfp_pkg::*;

  item_t push_item;
  item_t q_item;
  logic  push, full, pop, q_valid;

  ucfp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_item    (push_item)
  );

  ucfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  ucfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
